// ----- rtl/core/box_filter_window_sum_unit_macros.svh -----
// ----------------------------------------------------------------------------
// box filter window sum assertion macros
// shared concurrent assertion forms for the box filter window sum checker
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_WINDOW_SUM_UNIT_MACROS_SVH
`define BOX_FILTER_WINDOW_SUM_UNIT_MACROS_SVH

// same-cycle implication
`define BFWS_ASSERT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BFWS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/bfws_pkg.sv -----
// ----------------------------------------------------------------------------
// bfws_pkg
// shared widths, defaults and register map of the box filter window sum unit
// ----------------------------------------------------------------------------
package bfws_pkg;

    localparam int PIX_W       = 16;
    localparam int ROW_W       = 12;
    localparam int COL_OUT_W   = 12;
    localparam int CFG_W       = 9;
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = 3;
    localparam int EPOCH_W     = 8;

    localparam int BLOCK_PIXELS_DEF = 16;
    localparam int HALF_WIDTH_DEF   = 3;
    localparam int HALF_HEIGHT_DEF  = 3;
    localparam int WINDOW_ROWS_DEF  = 7;
    localparam int MAX_BLOCKS_DEF   = 256;

    localparam int BLOCKS_RESET     = 256;

    // register index taken from paddr[2]
    localparam logic REG_BLOCKS_PER_ROW = 1'b0;

endpackage

// ----- rtl/core/box_filter_window_sum_unit.sv -----
// ----------------------------------------------------------------------------
// box_filter_window_sum_unit
// streaming box filter: horizontal window sum per pixel, vertical sum through
// a ring of per-column running totals kept in one synchronous memory
// ----------------------------------------------------------------------------
//  channel  dir  handshake                    payload
//  pixel    in   pixel_valid / pixel_stall    pixel, frame_start
//  sum      out  sum_valid / sum_stall        box_sum, out_row, out_col
//  apb      in   psel / penable / pready      blocks_per_row at address 0
//
//  one pixel per cycle while pixel_stall is low; a result is registered
//  with the totals memory read and the update stage, then in the output register
//  after reset a clear pass over all WINDOW_ROWS * 2**clog2(ROW_SPAN) words
//  (28672 at defaults) holds pixel_stall high; the same pass runs before
//  the frame start that wraps the 8-bit frame tag, once every 255 frames
//  with sum stalled, one result waits in the output register and one more
//  in the update stage before pixel_stall rises
module box_filter_window_sum_unit
    import bfws_pkg::*;
#(
    parameter int BLOCK_PIXELS = BLOCK_PIXELS_DEF,
    parameter int HALF_WIDTH   = HALF_WIDTH_DEF,
    parameter int HALF_HEIGHT  = HALF_HEIGHT_DEF,
    parameter int WINDOW_ROWS  = WINDOW_ROWS_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  pixel_valid,
    output logic                  pixel_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  frame_start,

    output logic                  sum_valid,
    input  logic                  sum_stall,
    output logic [PIX_W-1:0]      box_sum,
    output logic [ROW_W-1:0]      out_row,
    output logic [COL_OUT_W-1:0]  out_col,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int HWIN_LEN  = 2 * HALF_WIDTH + 1;
    localparam int ROW_SPAN  = MAX_BLOCKS * BLOCK_PIXELS;
    localparam int COL_W     = $clog2(ROW_SPAN);
    localparam int CNT_W     = $clog2(ROW_SPAN + 1);
    localparam int SLOT_W    = (WINDOW_ROWS > 1) ? $clog2(WINDOW_ROWS) : 1;
    localparam int ADDR_W    = SLOT_W + COL_W;
    localparam int MEM_DEPTH = WINDOW_ROWS * (2 ** COL_W);
    localparam int WORD_W    = EPOCH_W + PIX_W;
    localparam int BLK_W     = $clog2(MAX_BLOCKS + 1);
    localparam int EFF_RST   = (BLOCKS_RESET > MAX_BLOCKS) ? MAX_BLOCKS : BLOCKS_RESET;
    localparam int WIDTH_RST = EFF_RST * BLOCK_PIXELS;
    localparam int LIMIT_RST = WIDTH_RST - BLOCK_PIXELS;

    // configuration
    logic [CFG_W-1:0]   blocks_reg;
    logic [CNT_W-1:0]   width_reg;
    logic [CNT_W-1:0]   limit_reg;
    logic [CFG_W-1:0]   cfg_wdata;
    logic [BLK_W-1:0]   eff_blocks;
    logic               cfg_write;

    // front state
    logic [PIX_W-1:0]   hwin_reg [HWIN_LEN];
    logic [PIX_W-1:0]   hwin_next [HWIN_LEN];
    logic [PIX_W-1:0]   hsum_reg;
    logic [PIX_W-1:0]   hsum_next;
    logic [CNT_W-1:0]   col_cnt_reg;
    logic [CNT_W-1:0]   col_cnt_next;
    logic [ROW_W-1:0]   row_cnt_reg;
    logic [ROW_W-1:0]   row_cnt_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [EPOCH_W-1:0] epoch_next;

    logic [CNT_W-1:0]   col_base;
    logic [ROW_W-1:0]   row_base;
    logic [SLOT_W-1:0]  slot_base;
    logic [SLOT_W-1:0]  prev_slot;
    logic [PIX_W-1:0]   hsum_win;
    logic [CNT_W-1:0]   col_tap;
    logic [CNT_W-1:0]   col_inc;
    logic               row_end;
    logic               access;
    logic               emit;
    logic               accept;
    logic               wrap_hold;
    logic [ADDR_W-1:0]  addr_cur;
    logic [ADDR_W-1:0]  addr_prev;

    // clear pass
    logic               clear_reg;
    logic               clear_next;
    logic [ADDR_W-1:0]  clr_addr_reg;
    logic [ADDR_W-1:0]  clr_addr_next;

    // totals memory
    logic [WORD_W-1:0]  totals_mem [MEM_DEPTH];
    logic [WORD_W-1:0]  rd_cur_reg;
    logic [WORD_W-1:0]  rd_prev_reg;

    // update stage
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic               s1_emit_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [PIX_W-1:0]   s1_hsum_reg;
    logic [ROW_W-1:0]   s1_row_reg;
    logic [COL_OUT_W-1:0] s1_col_reg;
    logic               s1_adv;
    logic [PIX_W-1:0]   prev_val;
    logic [PIX_W-1:0]   oldest_val;
    logic [PIX_W-1:0]   fresh;

    // output register
    logic               sum_valid_reg;
    logic [PIX_W-1:0]   box_sum_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_OUT_W-1:0] out_col_reg;

    // ------------------------------------------------------------------------
    // configuration port
    // ------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_BLOCKS_PER_ROW);
    assign cfg_wdata = pwdata[CFG_W-1:0];
    assign prdata    = (paddr[2] == REG_BLOCKS_PER_ROW)
                       ? APB_DATA_W'(blocks_reg) : '0;

    always_comb
    begin
        if (cfg_wdata < CFG_W'(2))
        begin
            eff_blocks = BLK_W'(2);
        end
        else if (32'(cfg_wdata) > 32'(MAX_BLOCKS))
        begin
            eff_blocks = BLK_W'(MAX_BLOCKS);
        end
        else
        begin
            eff_blocks = BLK_W'(cfg_wdata);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blocks_reg <= CFG_W'(BLOCKS_RESET);
            width_reg  <= CNT_W'(WIDTH_RST);
            limit_reg  <= CNT_W'(LIMIT_RST);
        end
        else if (cfg_write)
        begin
            blocks_reg <= cfg_wdata;
            width_reg  <= CNT_W'(eff_blocks * BLOCK_PIXELS);
            limit_reg  <= CNT_W'(eff_blocks * BLOCK_PIXELS - BLOCK_PIXELS);
        end
    end

    // ------------------------------------------------------------------------
    // pixel beat: window, counters, memory addresses
    // ------------------------------------------------------------------------
    assign s1_adv      = !sum_valid_reg || !sum_stall;
    assign wrap_hold   = pixel_valid && frame_start && (epoch_reg == '1);
    assign pixel_stall = clear_reg || wrap_hold || (s1_valid_reg && !s1_adv);
    assign accept      = pixel_valid && !pixel_stall;

    always_comb
    begin
        col_base  = frame_start ? '0 : col_cnt_reg;
        row_base  = frame_start ? '0 : row_cnt_reg;
        slot_base = frame_start ? '0 : slot_reg;
        hsum_win  = frame_start ? pixel : PIX_W'(hsum_reg + pixel - hwin_reg[HWIN_LEN-1]);

        col_tap   = col_base - CNT_W'(HALF_WIDTH);
        access    = (col_base >= CNT_W'(HALF_WIDTH)) && (col_tap < limit_reg);
        emit      = row_base >= ROW_W'(HALF_HEIGHT);
        prev_slot = (slot_base == '0) ? SLOT_W'(WINDOW_ROWS - 1) : slot_base - SLOT_W'(1);
        addr_cur  = {slot_base, col_tap[COL_W-1:0]};
        addr_prev = {prev_slot, col_tap[COL_W-1:0]};

        col_inc   = col_base + CNT_W'(1);
        row_end   = col_inc >= width_reg;

        if (row_end)
        begin
            col_cnt_next = '0;
            row_cnt_next = row_base + ROW_W'(1);
            slot_next    = (slot_base == SLOT_W'(WINDOW_ROWS - 1))
                           ? '0 : slot_base + SLOT_W'(1);
            hsum_next    = '0;
        end
        else
        begin
            col_cnt_next = col_inc;
            row_cnt_next = row_base;
            slot_next    = slot_base;
            hsum_next    = hsum_win;
        end

        hwin_next[0] = row_end ? '0 : pixel;
        for (int i = 1; i < HWIN_LEN; i++)
        begin
            hwin_next[i] = (row_end || frame_start) ? '0 : hwin_reg[i-1];
        end

        epoch_next = frame_start ? epoch_reg + EPOCH_W'(1) : epoch_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HWIN_LEN; i++)
            begin
                hwin_reg[i] <= '0;
            end
            hsum_reg    <= '0;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            slot_reg    <= '0;
        end
        else if (accept)
        begin
            for (int i = 0; i < HWIN_LEN; i++)
            begin
                hwin_reg[i] <= hwin_next[i];
            end
            hsum_reg    <= hsum_next;
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            slot_reg    <= slot_next;
        end
    end

    // ------------------------------------------------------------------------
    // frame tag and clear pass
    // ------------------------------------------------------------------------
    always_comb
    begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(MEM_DEPTH - 1))
            begin
                clear_next = 1'b0;
            end
        end
        else if (wrap_hold && !s1_valid_reg)
        begin
            clear_next    = 1'b1;
            clr_addr_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
            epoch_reg    <= '0;
        end
        else
        begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
            if (clear_reg && !clear_next)
            begin
                epoch_reg <= '0;
            end
            else if (accept)
            begin
                epoch_reg <= epoch_next;
            end
        end
    end

    // ------------------------------------------------------------------------
    // totals memory: two reads, one write
    // ------------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (clear_reg)
        begin
            totals_mem[clr_addr_reg] <= '0;
        end
        else if (s1_valid_reg && s1_adv)
        begin
            totals_mem[s1_addr_reg] <= {epoch_reg, fresh};
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && access)
        begin
            rd_cur_reg  <= totals_mem[addr_cur];
            rd_prev_reg <= totals_mem[addr_prev];
        end
    end

    // ------------------------------------------------------------------------
    // update stage
    // ------------------------------------------------------------------------
    assign prev_val   = (rd_prev_reg[WORD_W-1 -: EPOCH_W] == epoch_reg)
                        ? rd_prev_reg[PIX_W-1:0] : '0;
    assign oldest_val = (rd_cur_reg[WORD_W-1 -: EPOCH_W] == epoch_reg)
                        ? rd_cur_reg[PIX_W-1:0] : '0;
    assign fresh      = s1_hsum_reg + prev_val;

    always_comb
    begin
        if (accept)
        begin
            s1_valid_next = access;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_emit_reg <= emit;
            s1_addr_reg <= addr_cur;
            s1_hsum_reg <= hsum_win;
            s1_row_reg  <= row_base - ROW_W'(HALF_HEIGHT);
            s1_col_reg  <= COL_OUT_W'(col_tap);
        end
    end

    // ------------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            sum_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && s1_valid_reg && s1_emit_reg)
        begin
            box_sum_reg <= fresh - oldest_val;
            out_row_reg <= s1_row_reg;
            out_col_reg <= s1_col_reg;
        end
    end

    assign sum_valid = sum_valid_reg;
    assign box_sum   = box_sum_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;

endmodule

// ----- rtl/core/bfws_checker.sv -----
// ----------------------------------------------------------------------------
// bfws_checker
// port-level checks of the box filter window sum unit, bound to the top level
// ----------------------------------------------------------------------------
`include "box_filter_window_sum_unit_macros.svh"

module bfws_checker
    import bfws_pkg::*;
#(
    parameter int BLOCK_PIXELS = BLOCK_PIXELS_DEF,
    parameter int MAX_BLOCKS   = MAX_BLOCKS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 pixel_valid,
    input logic                 pixel_stall,
    input logic                 sum_valid,
    input logic                 sum_stall,
    input logic [PIX_W-1:0]     box_sum,
    input logic [ROW_W-1:0]     out_row,
    input logic [COL_OUT_W-1:0] out_col
);

    localparam int LAST_COLS = (MAX_BLOCKS - 1) * BLOCK_PIXELS;
    localparam int COL_BOUND = (LAST_COLS > 4096) ? 4096 : LAST_COLS;

    // a stalled result beat holds
    `BFWS_ASSERT_NEXT(a_sum_hold, clk, rst_n, sum_valid && sum_stall, sum_valid && $stable(box_sum) && $stable(out_row) && $stable(out_col), "stalled result beat changed")

    // a new result only follows a pixel beat that passed the update stage and the output register
    `BFWS_ASSERT(a_sum_cause, clk, rst_n, $rose(sum_valid), $past(pixel_valid && !pixel_stall, 2), "result without a pixel beat")

    // no result column lies in the last block of the widest row
    `BFWS_ASSERT(a_col_range, clk, rst_n, sum_valid, {1'b0, out_col} < 13'(COL_BOUND), "result column in last block")

endmodule

bind box_filter_window_sum_unit bfws_checker #(
    .BLOCK_PIXELS (BLOCK_PIXELS),
    .MAX_BLOCKS   (MAX_BLOCKS)
) u_bfws_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .sum_valid   (sum_valid),
    .sum_stall   (sum_stall),
    .box_sum     (box_sum),
    .out_row     (out_row),
    .out_col     (out_col)
);

// ----- verif/box_filter_window_sum_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box filter window sum checker
// watches the pixel, sum and register channels, keeps its own copy of the
// per-column totals and the horizontal taps, predicts every sum beat and
// compares the beats the block delivers in order, field by field
// ----------------------------------------------------------------------------
module box_filter_window_sum_checker
    import bfws_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  pixel_valid,
    input  logic                  pixel_stall,
    input  logic [PIX_W-1:0]      pixel,
    input  logic                  frame_start,

    input  logic                  sum_valid,
    input  logic                  sum_stall,
    input  logic [PIX_W-1:0]      box_sum,
    input  logic [ROW_W-1:0]      out_row,
    input  logic [COL_OUT_W-1:0]  out_col,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic [APB_DATA_W-1:0] prdata,
    input  logic                  pready,

    output int                    errors,
    output int                    pending,
    output int                    pixels_seen,
    output int                    sums_seen
);

    localparam int BLOCK_PIXELS = BLOCK_PIXELS_DEF;
    localparam int HALF_WIDTH   = HALF_WIDTH_DEF;
    localparam int HALF_HEIGHT  = HALF_HEIGHT_DEF;
    localparam int WINDOW_ROWS  = WINDOW_ROWS_DEF;
    localparam int MAX_BLOCKS   = MAX_BLOCKS_DEF;
    localparam int TAP_COUNT    = 2 * HALF_WIDTH + 1;
    localparam int STORE_COLS   = MAX_BLOCKS * BLOCK_PIXELS;
    localparam int ROW_WRAP     = 1 << ROW_W;
    localparam int REPORT_LIMIT = 20;

    typedef struct packed {
        logic [PIX_W-1:0]     sum;
        logic [ROW_W-1:0]     row;
        logic [COL_OUT_W-1:0] col;
    } sum_beat_t;

    logic [PIX_W-1:0] col_totals [WINDOW_ROWS][STORE_COLS];
    logic [PIX_W-1:0] recent_pixels [TAP_COUNT];
    int unsigned      col_pos;
    int unsigned      row_pos;
    int unsigned      ring_row;
    logic [CFG_W-1:0] blocks_cfg;
    sum_beat_t        expected_sums[$];

    initial
    begin
        errors      = 0;
        pending     = 0;
        pixels_seen = 0;
        sums_seen   = 0;
    end

    function automatic void wipe_store();
        int s;
        int k;
        for (s = 0; s < WINDOW_ROWS; s++)
        begin
            for (k = 0; k < STORE_COLS; k++)
            begin
                col_totals[s][k] = '0;
            end
        end
        for (k = 0; k < TAP_COUNT; k++)
        begin
            recent_pixels[k] = '0;
        end
        col_pos  = 0;
        row_pos  = 0;
        ring_row = 0;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        errors++;
        if (errors <= REPORT_LIMIT)
        begin
            $display("%0t: %s differs, expected %0d, got %0d", $realtime, what, want, got);
        end
    endtask

    task automatic advance_box_sum(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned      nblk;
        int unsigned      width;
        int unsigned      lim;
        int unsigned      c;
        int unsigned      back_slot;
        int               i;
        logic [PIX_W-1:0] hsum;
        logic [PIX_W-1:0] prev;
        logic [PIX_W-1:0] oldest;
        logic [PIX_W-1:0] fresh;
        sum_beat_t        beat;
        nblk = blocks_cfg;
        if (nblk < 2)
        begin
            nblk = 2;
        end
        if (nblk > MAX_BLOCKS)
        begin
            nblk = MAX_BLOCKS;
        end
        width = nblk * BLOCK_PIXELS;
        lim   = width - BLOCK_PIXELS;
        if (fs)
        begin
            wipe_store();
        end
        for (i = TAP_COUNT - 1; i > 0; i--)
        begin
            recent_pixels[i] = recent_pixels[i - 1];
        end
        recent_pixels[0] = pix;
        hsum = '0;
        for (i = 0; i < TAP_COUNT; i++)
        begin
            hsum = hsum + recent_pixels[i];
        end
        if (col_pos >= HALF_WIDTH)
        begin
            c = col_pos - HALF_WIDTH;
            if (c < lim && c < STORE_COLS)
            begin
                back_slot = (ring_row + WINDOW_ROWS - 1) % WINDOW_ROWS;
                prev      = col_totals[back_slot][c];
                oldest    = col_totals[ring_row][c];
                fresh     = hsum + prev;
                col_totals[ring_row][c] = fresh;
                if (row_pos >= HALF_HEIGHT)
                begin
                    beat.sum = fresh - oldest;
                    beat.row = ROW_W'(row_pos - HALF_HEIGHT);
                    beat.col = COL_OUT_W'(c);
                    expected_sums.push_back(beat);
                end
            end
        end
        col_pos++;
        if (col_pos >= width)
        begin
            col_pos = 0;
            for (i = 0; i < TAP_COUNT; i++)
            begin
                recent_pixels[i] = '0;
            end
            row_pos  = (row_pos + 1) % ROW_WRAP;
            ring_row = (ring_row + 1) % WINDOW_ROWS;
        end
    endtask

    always @(posedge clk)
    begin : watch
        sum_beat_t want;
        if (!rst_n)
        begin
            wipe_store();
            blocks_cfg = CFG_W'(BLOCKS_RESET);
            expected_sums.delete();
        end
        else
        begin
            if (psel && penable && pready && paddr[2] == REG_BLOCKS_PER_ROW)
            begin
                if (pwrite)
                begin
                    blocks_cfg = pwdata[CFG_W-1:0];
                end
                else if (prdata[CFG_W-1:0] !== blocks_cfg)
                begin
                    report_mismatch("blocks_per_row readback", blocks_cfg, prdata[CFG_W-1:0]);
                end
            end
            if (pixel_valid && !pixel_stall)
            begin
                advance_box_sum(pixel, frame_start);
                pixels_seen++;
            end
            if (sum_valid && !sum_stall)
            begin
                sums_seen++;
                if (expected_sums.size() == 0)
                begin
                    report_mismatch("unexpected sum beat, box_sum", 0, box_sum);
                end
                else
                begin
                    want = expected_sums.pop_front();
                    if (box_sum !== want.sum)
                    begin
                        report_mismatch("box_sum", want.sum, box_sum);
                    end
                    if (out_row !== want.row)
                    begin
                        report_mismatch("out_row", want.row, out_row);
                    end
                    if (out_col !== want.col)
                    begin
                        report_mismatch("out_col", want.col, out_col);
                    end
                end
            end
        end
        pending = expected_sums.size();
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box filter window sum unit testbench
// streams pixel frames at several row widths through the block, from the
// narrowest to the widest, with random gaps and stalls on both channels,
// a long receiver hold, mid-row width changes and a frame tag rollover;
// the checker predicts and compares every sum beat
// ----------------------------------------------------------------------------
module tb_top;
    import bfws_pkg::*;

    localparam int BLOCK_PIXELS   = BLOCK_PIXELS_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 120000;
    localparam int RAND_ITEMS     = 300;

    typedef enum {FILL_RANDOM, FILL_MAX, FILL_ZERO} fill_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_stall;
    logic [PIX_W-1:0]      pixel = '0;
    logic                  frame_start = 1'b0;
    logic                  sum_valid;
    logic                  sum_stall = 1'b0;
    logic [PIX_W-1:0]      box_sum;
    logic [ROW_W-1:0]      out_row;
    logic [COL_OUT_W-1:0]  out_col;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int errors;
    int pending;
    int pixels_seen;
    int sums_seen;

    int cur_width = MAX_BLOCKS_DEF * BLOCK_PIXELS;
    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit hold_req = 1'b0;
    int cfg_writes = 0;
    int frames_sent = 0;
    int holds_done = 0;
    int quiet_cycles = 0;

    box_filter_window_sum_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .sum_valid   (sum_valid),
        .sum_stall   (sum_stall),
        .box_sum     (box_sum),
        .out_row     (out_row),
        .out_col     (out_col),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    box_filter_window_sum_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .frame_start (frame_start),
        .sum_valid   (sum_valid),
        .sum_stall   (sum_stall),
        .box_sum     (box_sum),
        .out_row     (out_row),
        .out_col     (out_col),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .errors      (errors),
        .pending     (pending),
        .pixels_seen (pixels_seen),
        .sums_seen   (sums_seen)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pixel_valid && !pixel_stall) || (sum_valid && !sum_stall))
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("box_filter_window_sum_unit: mismatch");
            $finish;
        end
    end

    initial
    begin : receiver
        int   run_left;
        int   r;
        logic stall_now;
        run_left  = 0;
        stall_now = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                sum_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
                holds_done++;
            end
            else
            begin
                if (run_left == 0)
                begin
                    r = $urandom_range(0, 99);
                    if (!rx_idle_on || r < 55)
                    begin
                        stall_now = 1'b0;
                        run_left  = $urandom_range(1, 12);
                    end
                    else if (r < 95)
                    begin
                        stall_now = 1'b1;
                        run_left  = $urandom_range(1, 3);
                    end
                    else
                    begin
                        stall_now = 1'b1;
                        run_left  = $urandom_range(10, 60);
                    end
                end
                run_left--;
                sum_stall <= stall_now;
            end
        end
    end

    function automatic logic [PIX_W-1:0] pick_pixel(input fill_t fill);
        logic [PIX_W-1:0] value;
        case (fill)
            FILL_MAX:  value = '1;
            FILL_ZERO: value = '0;
            default:
            begin
                case ($urandom_range(0, 9))
                    0:       value = '0;
                    1:       value = '1;
                    2:       value = PIX_W'(1) << $urandom_range(0, PIX_W - 1);
                    default: value = PIX_W'($urandom);
                endcase
            end
        endcase
        return value;
    endfunction

    task automatic send_pixel(input logic [PIX_W-1:0] value, input logic fs);
        int r;
        int gap;
        gap = 0;
        if (tx_idle_on)
        begin
            r = $urandom_range(0, 99);
            if (r >= 97)
            begin
                gap = $urandom_range(10, 50);
            end
            else if (r >= 70)
            begin
                gap = $urandom_range(1, 3);
            end
        end
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= value;
        frame_start <= fs;
        do @(posedge clk); while (pixel_stall);
        if (fs)
        begin
            frames_sent++;
        end
    endtask

    task automatic send_run(input int count, input fill_t fill, input logic fs_first,
                            input bit noise);
        int   k;
        logic fs;
        for (k = 0; k < count; k++)
        begin
            fs = (k == 0) ? fs_first : (noise && $urandom_range(0, 15) == 0);
            send_pixel(pick_pixel(fill), fs);
        end
    endtask

    // let the last beat of the pipeline drain before touching the register
    task automatic settle();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_access(input bit do_write, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        int                    eff;
        word             = $urandom;
        word[CFG_W-1:0]  = value;
        if (do_write)
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= {REG_BLOCKS_PER_ROW, 2'b00};
            pwdata  <= word;
            @(posedge clk);
            penable <= 1'b1;
            do @(posedge clk); while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            @(posedge clk);
            cfg_writes++;
            eff = value < 2 ? 2 : (value > MAX_BLOCKS_DEF ? MAX_BLOCKS_DEF : value);
            cur_width = eff * BLOCK_PIXELS;
        end
        psel   <= 1'b1;
        pwrite <= 1'b0;
        paddr  <= {REG_BLOCKS_PER_ROW, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        int          sent;
        int          rows;
        int          kind;
        int          count;
        int          r;
        logic        fs;
        bit          noise;
        logic [CFG_W-1:0] blk;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        reg_access(1'b0, '0);
        reg_access(1'b1, CFG_W'(2));
        send_run(4 * cur_width, FILL_MAX, 1'b1, 1'b0);
        send_run(4 * cur_width, FILL_ZERO, 1'b1, 1'b0);
        settle();
        reg_access(1'b1, CFG_W'(0));
        send_run(4 * cur_width, FILL_RANDOM, 1'b1, 1'b0);
        settle();
        reg_access(1'b1, CFG_W'(3));
        send_run(4 * cur_width, FILL_RANDOM, 1'b1, 1'b0);

        // row shrinks under a column already past the new width
        settle();
        reg_access(1'b1, '1);
        send_run(60, FILL_RANDOM, 1'b1, 1'b0);
        settle();
        reg_access(1'b1, CFG_W'(2));
        send_run(1 + 4 * cur_width, FILL_RANDOM, 1'b0, 1'b0);

        // long receiver hold while pixels keep coming
        tx_idle_on = 1'b0;
        hold_req   = 1'b1;
        send_run(8 * cur_width, FILL_RANDOM, 1'b1, 1'b0);
        tx_idle_on = 1'b1;

        sent = 0;
        while (sent < RAND_ITEMS)
        begin
            if ($urandom_range(0, 99) < 30)
            begin
                r = $urandom_range(0, 9);
                if (r < 8)
                begin
                    blk = CFG_W'($urandom_range(2, 4));
                end
                else if (r == 8)
                begin
                    blk = CFG_W'($urandom_range(0, 1));
                end
                else
                begin
                    blk = CFG_W'($urandom_range(5, 8));
                end
                settle();
                reg_access(1'b1, blk);
            end
            tx_idle_on = $urandom_range(0, 3) != 0;
            rx_idle_on = $urandom_range(0, 3) != 0;
            rows  = $urandom_range(1, 7);
            kind  = $urandom_range(0, 9);
            fs    = 1'b1;
            noise = 1'b0;
            count = rows * cur_width;
            if (kind == 6 || kind == 7)
            begin
                count = $urandom_range(1, rows * cur_width);
            end
            else if (kind == 8)
            begin
                fs = 1'b0;
            end
            else if (kind == 9)
            begin
                count = $urandom_range(20, 80);
                fs    = 1'($urandom_range(0, 1));
                noise = 1'b1;
            end
            if (count > RAND_ITEMS - sent)
            begin
                count = RAND_ITEMS - sent;
            end
            send_run(count, FILL_RANDOM, fs, noise);
            sent += count;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;

        settle();
        reg_access(1'b1, CFG_W'(MAX_BLOCKS_DEF));
        send_run(60, FILL_RANDOM, 1'b1, 1'b0);

        // enough frames to roll the frame tag over
        settle();
        reg_access(1'b1, CFG_W'(2));
        repeat (260) send_pixel(pick_pixel(FILL_RANDOM), 1'b1);
        send_run(4 * cur_width, FILL_RANDOM, 1'b1, 1'b0);

        settle();
        $display("covered %0d pixel beats and %0d sum beats in %0d frames",
                 pixels_seen, sums_seen, frames_sent);
        $display("rows of %0d to %0d pixels, %0d register writes, %0d long receiver holds",
                 2 * BLOCK_PIXELS, MAX_BLOCKS_DEF * BLOCK_PIXELS, cfg_writes, holds_done);
        if (errors == 0 && pending == 0)
        begin
            $display("box_filter_window_sum_unit: match");
        end
        else
        begin
            $display("box_filter_window_sum_unit: mismatch");
        end
        $finish;
    end

endmodule

// ----- box_filter_window_sum_unit.f -----
+incdir+rtl/core
rtl/core/bfws_pkg.sv
rtl/core/box_filter_window_sum_unit.sv
rtl/core/bfws_checker.sv
verif/box_filter_window_sum_checker.sv
verif/tb_top.sv
